// ----- sv/rotating_slot_allocator_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the rotating slot allocator
// Shared concurrent assertion forms, clocked on clk and reset by rst.
// ----------------------------------------------------------------------------
`ifndef ROTATING_SLOT_ALLOCATOR_UNIT_ASSERT_SVH
`define ROTATING_SLOT_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define RSA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define RSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Condition that must hold in the cycle right after reset.
`define RSA_ASSERT_AFTER_RESET(label, cons) \
  label: assert property (@(posedge clk) $past(rst) |-> (cons)) \
    else $error("assertion failed after reset");

`endif

// ----- sv/rsa_pkg.sv -----
// ----------------------------------------------------------------------------
// rsa_pkg
// Types and constants of the rotating slot allocator.
// ----------------------------------------------------------------------------
package rsa_pkg;

  localparam int SLOT_COUNT = 64;
  localparam int REF_BITS   = 16;
  localparam int SLOT_BITS  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Item field widths are fixed by the interface.
  typedef logic [1:0]  kind_t;
  typedef logic [15:0] field_ref_t;
  typedef logic [5:0]  field_slot_t;

  // Table-side widths.
  typedef logic [SLOT_BITS-1:0] slot_t;
  typedef logic [REF_BITS-1:0]  ref_t;

  localparam kind_t KIND_OPEN  = 2'd0;
  localparam kind_t KIND_CLOSE = 2'd1;
  localparam kind_t KIND_QUERY = 2'd2;

  typedef struct packed {
    kind_t       kind;
    field_ref_t  entry_ref;
    field_slot_t slot_index;
  } req_t;

  typedef struct packed {
    logic        ok;
    field_slot_t slot;
    field_ref_t  stored_ref;
  } rsp_t;

endpackage

// ----- sv/rsa_ram.sv -----
// ----------------------------------------------------------------------------
// rsa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/rotating_slot_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// rotating_slot_allocator_unit
// Next-fit handle table: open, close and query of reference slots.
// ----------------------------------------------------------------------------
// Every item passes through the accept cycle, which launches a read of the
// reference RAM at the requested slot, and the execute cycle, which uses the
// registered read data, runs the next-fit search over the in-use bits and
// writes the RAM and the in-use bits back. One item is in flight at a time,
// so no new item is taken before the last one has executed; the limit is the
// registered read port of the reference RAM. The result sits in an output
// register, so the next item is taken while a result still waits; only when
// that result is still stalled at the execute cycle does the block hold.
// In-use bits are flip-flops cleared by reset; the reference RAM is never
// cleared, since a free slot always answers zero.
// ----------------------------------------------------------------------------
module rotating_slot_allocator_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  rsa_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output rsa_pkg::rsp_t rsp
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                             state;
  logic                             state_next;
  rsa_pkg::req_t                    req_q;
  logic [rsa_pkg::SLOT_COUNT-1:0]   in_use;
  logic [rsa_pkg::SLOT_COUNT-1:0]   in_use_next;
  rsa_pkg::slot_t                   cursor;
  rsa_pkg::slot_t                   cursor_next;
  rsa_pkg::rsp_t                    rsp_next;

  // Reference RAM ports.
  logic                             ram_we;
  rsa_pkg::slot_t                   ram_waddr;
  rsa_pkg::ref_t                    ram_wdata;
  rsa_pkg::ref_t                    ram_rdata;

  // Next-fit search.
  logic [rsa_pkg::SLOT_COUNT-1:0]   free_mask;
  logic [rsa_pkg::SLOT_COUNT-1:0]   above_mask;
  logic [rsa_pkg::SLOT_COUNT-1:0]   pick_mask;
  logic [rsa_pkg::SLOT_COUNT-1:0]   first_free;
  rsa_pkg::slot_t                   grant_idx;

  logic                             accept;
  logic                             exec_go;
  logic                             idx_ok;
  rsa_pkg::slot_t                   slot_sel;
  rsa_pkg::ref_t                    open_ref;

  // One item at a time: busy from accept until the execute cycle retires.
  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  // Execute only when the output register is free or being emptied.
  assign exec_go   = (state == ST_EXEC) && (!rsp_valid || !rsp_stall);

  assign idx_ok    = int'(req_q.slot_index) < rsa_pkg::SLOT_COUNT;
  assign slot_sel  = rsa_pkg::slot_t'(req_q.slot_index);
  assign open_ref  = rsa_pkg::ref_t'(req_q.entry_ref);

  rsa_ram #(
    .WIDTH (rsa_pkg::REF_BITS),
    .DEPTH (rsa_pkg::SLOT_COUNT)
  ) u_ref_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (rsa_pkg::slot_t'(req.slot_index)),
    .rdata (ram_rdata)
  );

  // Next-fit: first free slot strictly above the cursor, else the first free
  // slot from zero (wraparound). Lowest set bit isolated by x & -x.
  always_comb begin
    free_mask = ~in_use;
    for (int i = 0; i < rsa_pkg::SLOT_COUNT; i++) begin
      above_mask[i] = (i > int'(cursor));
    end
    pick_mask  = (|(free_mask & above_mask)) ? (free_mask & above_mask) : free_mask;
    first_free = pick_mask & (-pick_mask);
    grant_idx  = '0;
    for (int i = 0; i < rsa_pkg::SLOT_COUNT; i++) begin
      if (first_free[i]) begin
        grant_idx = grant_idx | rsa_pkg::slot_t'(i);
      end
    end
  end

  // Execute cycle: decode the held item, build the result and the write-back.
  always_comb begin
    in_use_next = in_use;
    cursor_next = cursor;
    ram_we      = 1'b0;
    ram_waddr   = grant_idx;
    ram_wdata   = open_ref;
    rsp_next.ok         = 1'b0;
    rsp_next.slot       = req_q.slot_index;
    rsp_next.stored_ref = '0;
    unique case (req_q.kind)
      rsa_pkg::KIND_OPEN: begin
        rsp_next.slot = '0;
        if (|free_mask) begin
          ram_we                 = exec_go;
          in_use_next[grant_idx] = 1'b1;
          rsp_next.ok            = 1'b1;
          rsp_next.slot          = rsa_pkg::field_slot_t'(grant_idx);
          rsp_next.stored_ref    = rsa_pkg::field_ref_t'(open_ref);
        end
      end
      rsa_pkg::KIND_CLOSE: begin
        rsp_next.ok = 1'b1;
        if (idx_ok) begin
          in_use_next[slot_sel] = 1'b0;
          cursor_next           = slot_sel;
        end
      end
      rsa_pkg::KIND_QUERY: begin
        if (idx_ok && in_use[slot_sel]) begin
          rsp_next.ok         = 1'b1;
          rsp_next.stored_ref = rsa_pkg::field_ref_t'(ram_rdata);
        end
      end
      default: begin
        // Undefined kind: echo the index, no state change.
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_EXEC;
      ST_EXEC: if (exec_go) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      in_use    <= '0;
      cursor    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (exec_go) begin
        in_use    <= in_use_next;
        cursor    <= cursor_next;
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    if (exec_go) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ----- sv/rsa_checker.sv -----
// ----------------------------------------------------------------------------
// rsa_checker
// Port-level checks of the rotating slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "rotating_slot_allocator_unit_assert.svh"

module rsa_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input rsa_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input rsa_pkg::rsp_t rsp
);

  // A stalled result stays offered.
  `RSA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)

  // Only one item in flight: an accept closes the input.
  `RSA_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

  // After every accept a result is offered: that item's, or an older one still stalled.
  `RSA_ASSERT_SAME(a_result_follows,
    $past(req_valid && !req_stall && !rst, 2) && !$past(rst), rsp_valid)

  // Reset leaves no result pending and the input open.
  `RSA_ASSERT_AFTER_RESET(a_reset_clean, !rsp_valid && !req_stall)

endmodule

bind rotating_slot_allocator_unit rsa_checker u_rsa_checker (.*);

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb: rotating slot allocator testbench
// Runs a short table of directed items, then random open, close, query and
// meaningless items with random idling on both sides. Each result is checked
// against its hand-typed result, else a next-fit handle table model in the tb.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Kind with no meaning; the block answers and ignores it.
  localparam rsa_pkg::kind_t KIND_NONE = 2'd3;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int ITEM_TARGET  = 1400;
  localparam int IDLE_PERCENT = 34;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 8;

  // One row of the directed table: the item and, where it is obvious,
  // the result typed in by hand.
  typedef struct packed {
    rsa_pkg::req_t item;
    logic          typed;
    rsa_pkg::rsp_t want;
  } stim_row_t;

  localparam int ROW_COUNT = 21;

  localparam stim_row_t DIRECTED_ROWS [ROW_COUNT] = '{
    // Fresh table: every slot reads free.
    '{'{rsa_pkg::KIND_QUERY, 16'h0000, 6'd0},  1'b1, '{1'b0, 6'd0,  16'h0000}},
    '{'{rsa_pkg::KIND_QUERY, 16'h1234, 6'd63}, 1'b1, '{1'b0, 6'd63, 16'h0000}},
    // First opens land upward from one past the reset cursor.
    '{'{rsa_pkg::KIND_OPEN,  16'hFFFF, 6'd0},  1'b1, '{1'b1, 6'd1,  16'hFFFF}},
    '{'{rsa_pkg::KIND_OPEN,  16'h0000, 6'd63}, 1'b1, '{1'b1, 6'd2,  16'h0000}},
    '{'{rsa_pkg::KIND_QUERY, 16'h0000, 6'd1},  1'b1, '{1'b1, 6'd1,  16'hFFFF}},
    // In use but holding a zero reference.
    '{'{rsa_pkg::KIND_QUERY, 16'hFFFF, 6'd2},  1'b1, '{1'b1, 6'd2,  16'h0000}},
    '{'{rsa_pkg::KIND_CLOSE, 16'h0000, 6'd1},  1'b1, '{1'b1, 6'd1,  16'h0000}},
    '{'{rsa_pkg::KIND_OPEN,  16'h1234, 6'd0},  1'b0, '0},
    '{'{rsa_pkg::KIND_QUERY, 16'h0000, 6'd1},  1'b1, '{1'b0, 6'd1,  16'h0000}},
    // Closing a free slot still moves the cursor; next open wraps to 0.
    '{'{rsa_pkg::KIND_CLOSE, 16'h0000, 6'd63}, 1'b1, '{1'b1, 6'd63, 16'h0000}},
    '{'{rsa_pkg::KIND_OPEN,  16'hAAAA, 6'd0},  1'b0, '0},
    '{'{KIND_NONE,           16'hFFFF, 6'd45}, 1'b1, '{1'b0, 6'd45, 16'h0000}},
    '{'{KIND_NONE,           16'h0000, 6'd0},  1'b1, '{1'b0, 6'd0,  16'h0000}},
    '{'{rsa_pkg::KIND_CLOSE, 16'hFFFF, 6'd40}, 1'b1, '{1'b1, 6'd40, 16'h0000}},
    '{'{rsa_pkg::KIND_OPEN,  16'h5555, 6'd21}, 1'b0, '0},
    '{'{rsa_pkg::KIND_QUERY, 16'h0000, 6'd41}, 1'b0, '0},
    '{'{rsa_pkg::KIND_CLOSE, 16'h0000, 6'd0},  1'b1, '{1'b1, 6'd0,  16'h0000}},
    '{'{rsa_pkg::KIND_OPEN,  16'h0001, 6'd0},  1'b0, '0},
    '{'{rsa_pkg::KIND_QUERY, 16'h0000, 6'd63}, 1'b1, '{1'b0, 6'd63, 16'h0000}},
    '{'{rsa_pkg::KIND_CLOSE, 16'h0000, 6'd2},  1'b1, '{1'b1, 6'd2,  16'h0000}},
    '{'{rsa_pkg::KIND_OPEN,  16'h8000, 6'd63}, 1'b0, '0}
  };

  logic          clk;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_stall;
  rsa_pkg::req_t req       = '0;
  logic          rsp_valid;
  logic          rsp_stall = 1'b0;
  rsa_pkg::rsp_t rsp;

  rotating_slot_allocator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Handle table model: in-use bits, held references and the cursor.
  // --------------------------------------------------------------------------
  bit            taken    [rsa_pkg::SLOT_COUNT];
  rsa_pkg::ref_t held_ref [rsa_pkg::SLOT_COUNT];
  int            cursor_pos;
  int            slots_taken;

  rsa_pkg::rsp_t expected_results[$];

  int opens_granted, opens_refused, closes_done, query_hits, query_misses;
  int ignored_items, issued, results_seen, fail_count;
  bit calm;   // no idling on either side while set

  // Next-fit search from one past the cursor; open leaves the cursor alone.
  function automatic rsa_pkg::rsp_t table_step(input rsa_pkg::req_t item);
    rsa_pkg::rsp_t res;
    int            pos;
    res      = '0;
    res.slot = item.slot_index;
    case (item.kind)
      rsa_pkg::KIND_OPEN: begin
        res.slot = '0;
        pos = cursor_pos;
        for (int n = 0; n < rsa_pkg::SLOT_COUNT; n++) begin
          pos = (pos == rsa_pkg::SLOT_COUNT - 1) ? 0 : pos + 1;
          if (!taken[pos]) begin
            taken[pos]     = 1'b1;
            held_ref[pos]  = item.entry_ref;
            slots_taken++;
            opens_granted++;
            res.ok         = 1'b1;
            res.slot       = rsa_pkg::field_slot_t'(pos);
            res.stored_ref = item.entry_ref;
            return res;
          end
        end
        opens_refused++;   // table full: nothing changes
      end
      rsa_pkg::KIND_CLOSE: begin
        if (taken[item.slot_index]) slots_taken--;
        taken[item.slot_index] = 1'b0;
        cursor_pos = int'(item.slot_index);
        closes_done++;
        res.ok = 1'b1;
      end
      rsa_pkg::KIND_QUERY: begin
        if (taken[item.slot_index]) begin
          res.ok         = 1'b1;
          res.stored_ref = held_ref[item.slot_index];
          query_hits++;
        end else begin
          query_misses++;
        end
      end
      default: begin
        ignored_items++;
      end
    endcase
    return res;
  endfunction

  function automatic rsa_pkg::req_t make_item(input rsa_pkg::kind_t k);
    rsa_pkg::req_t item;
    item.kind       = k;
    item.entry_ref  = rsa_pkg::field_ref_t'($urandom_range(16'hFFFF));
    item.slot_index = rsa_pkg::field_slot_t'($urandom_range(rsa_pkg::SLOT_COUNT - 1));
    return item;
  endfunction

  // Offer one item, wait for it to be taken, then record what it must give.
  task automatic send_item(input rsa_pkg::req_t item, input logic typed,
                           input rsa_pkg::rsp_t want);
    int            gap;
    rsa_pkg::rsp_t predicted;
    gap = 0;
    while (!calm && $urandom_range(99) < IDLE_PERCENT) gap++;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (req_stall);
    predicted = table_step(item);
    expected_results.push_back(typed ? want : predicted);
    if (item.kind != KIND_NONE) issued++;
    calm = (issued >= 500 && issued < 700);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus: directed table, then random episodes.
  // --------------------------------------------------------------------------
  initial begin
    int             episode, len, pick;
    rsa_pkg::kind_t k;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[i])
      send_item(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

    while (issued < ITEM_TARGET) begin
      episode = $urandom_range(9);
      if (episode < 2) begin
        // Fill: opens, with the odd query, until the table is full, then one to four refused opens.
        len = $urandom_range(4, 1);
        while (slots_taken < rsa_pkg::SLOT_COUNT) begin
          k = ($urandom_range(7) == 0) ? rsa_pkg::KIND_QUERY : rsa_pkg::KIND_OPEN;
          send_item(make_item(k), 1'b0, '0);
        end
        repeat (len) send_item(make_item(rsa_pkg::KIND_OPEN), 1'b0, '0);
      end else if (episode < 4) begin
        // Drain: mostly closes, some queries to see the freed slots.
        len = $urandom_range(50, 20);
        repeat (len) begin
          k = ($urandom_range(3) == 0) ? rsa_pkg::KIND_QUERY : rsa_pkg::KIND_CLOSE;
          send_item(make_item(k), 1'b0, '0);
        end
      end else begin
        // Mixed traffic, with the odd meaningless kind.
        len = $urandom_range(40, 20);
        repeat (len) begin
          pick = $urandom_range(99);
          if (pick < 40)      k = rsa_pkg::KIND_OPEN;
          else if (pick < 65) k = rsa_pkg::KIND_CLOSE;
          else if (pick < 95) k = rsa_pkg::KIND_QUERY;
          else                k = KIND_NONE;
          send_item(make_item(k), 1'b0, '0);
        end
      end
    end
    req_valid <= 1'b0;
    calm = 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d opens granted, %0d refused on a full table, %0d closes",
             opens_granted, opens_refused, closes_done);
    $display("queries: %0d in use, %0d free; %0d ignored items; %0d results checked",
             query_hits, query_misses, ignored_items, results_seen);
    if (fail_count == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: random stall, two long hold-offs, and the field compare.
  // --------------------------------------------------------------------------
  int hold_left;
  int holds_done;

  always @(posedge clk) begin
    rsa_pkg::rsp_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected: ok %0d slot %0d ref %h",
                   $time, rsp.ok, rsp.slot, rsp.stored_ref);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (rsp.ok !== want.ok) begin
            $display("%0t: ok mismatch, expected %0d, got %0d", $time, want.ok, rsp.ok);
            fail_count++;
          end
          if (rsp.slot !== want.slot) begin
            $display("%0t: slot mismatch, expected %0d, got %0d",
                     $time, want.slot, rsp.slot);
            fail_count++;
          end
          if (rsp.stored_ref !== want.stored_ref) begin
            $display("%0t: stored_ref mismatch, expected %h, got %h",
                     $time, want.stored_ref, rsp.stored_ref);
            fail_count++;
          end
        end
      end

      // Long hold-offs let the block back up into its input.
      if (hold_left == 0 && ((holds_done == 0 && results_seen >= 400) ||
                             (holds_done == 1 && results_seen >= 1000))) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        rsp_stall <= 1'b1;
        hold_left--;
      end else begin
        rsp_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
      end
    end
  end

  // Watchdog.
  int cycle_count;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("tb NOT OK");
      $finish;
    end
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/rsa_pkg.sv
sv/rsa_ram.sv
sv/rotating_slot_allocator_unit.sv
sv/rsa_checker.sv
verif/tb.sv
